// File: hw/rtl/pta_pkg.sv
`timescale 1ns / 1ps

package pta_pkg;

    // Register stages from input capture to the output register
    localparam int NUM_STAGES = 6;

    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int NUM_W   = 18;   // signed numerators of both percent divisions
    localparam int QUOT_W  = 15;   // numerator bits below the clamp point

    // floor(n / 100) as (n * 41944) >> 22, exact for n < 43690
    localparam logic [15:0] RECIP100 = 16'd41944;
    localparam int          SHIFT100 = 22;
    localparam logic signed [NUM_W-1:0] CLAMP_NUM = 18'sd25600;

    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_CONTRAST   = 3'd1,
        REG_SATURATION = 3'd2,
        REG_GRAYSCALE  = 3'd3
    } cfg_index_t;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    // Divide a percent numerator by 100 and clamp to 0..255. Negative numerators
    // give zero for both floor and truncating division once clamped.
    function automatic logic [CHAN_W-1:0] div100_clamp(input logic signed [NUM_W-1:0] num);
        logic [30:0] prod;
        logic [CHAN_W-1:0] res;
        prod = 31'(num[QUOT_W-1:0]) * 31'(RECIP100);
        if (num[NUM_W-1]) begin
            res = '0;
        end else if (num >= CLAMP_NUM) begin
            res = '1;
        end else begin
            res = prod[SHIFT100+CHAN_W-1:SHIFT100];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/pixel_tone_adjust_core.sv
`timescale 1ns / 1ps

// Per-pixel brightness, contrast and saturation adjust.
//
// Input channel: in_valid / in_stall with red_in, green_in, blue_in. A word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with red_out, green_out, blue_out; the
// receiver holds out_stall high to keep the current word on the output.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data. Index 0 is
// brightness, 1 contrast, 2 saturation, 3 grayscale (bit 0); other indexes are
// dropped. cfg_ready is always high. Write config only while no word is in flight.
//
// Throughput is one pixel per clock while out_stall is low: six register stages
// (tone multiply, tone divide, luma sum, luma divide, saturation multiply,
// saturation divide/clamp) each take a word every cycle, and out_valid rises
// when a word reaches the last one. Under out_stall the pipeline closes its
// bubbles first and only raises in_stall once all six stages hold a word;
// nothing is lost or repeated.
// Reset empties the pipeline and returns all config registers to zero
// (neutral settings, which pass pixels through unchanged).
module pixel_tone_adjust_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import pta_pkg::*;

    logic signed [7:0] brightness_reg;
    logic signed [7:0] contrast_reg;
    logic signed [7:0] saturation_reg;
    logic              grayscale_reg;

    pipe_ctl_t             ctl;
    logic [NUM_STAGES-1:0] stage_valid;
    pixel_t                pix_in;
    pixel_t                tone;
    pixel_t                tone_d;
    logic [7:0]            gray;
    pixel_t                pix_out;

    // Config registers: take every write, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= '0;
            contrast_reg   <= '0;
            saturation_reg <= '0;
            grayscale_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_data;
                REG_CONTRAST:   contrast_reg   <= cfg_data;
                REG_SATURATION: saturation_reg <= cfg_data;
                REG_GRAYSCALE:  grayscale_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Valid bits and per-stage load enables
    pta_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .stage_valid (stage_valid),
        .ctl         (ctl)
    );

    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;

    // Stages 1-2: contrast and brightness per channel
    pta_tone u_tone (
        .clk        (clk),
        .load_num   (ctl.load[0]),
        .load_tone  (ctl.load[1]),
        .brightness (brightness_reg),
        .contrast   (contrast_reg),
        .pix        (pix_in),
        .tone       (tone)
    );

    // Stages 3-4: luma of the adjusted pixel
    pta_luma u_luma (
        .clk       (clk),
        .load_sum  (ctl.load[2]),
        .load_gray (ctl.load[3]),
        .tone      (tone),
        .tone_d    (tone_d),
        .gray      (gray)
    );

    // Stages 5-6: saturation about luma, result lands in the output register
    pta_mix u_mix (
        .clk        (clk),
        .load_num   (ctl.load[4]),
        .load_out   (ctl.load[5]),
        .saturation (saturation_reg),
        .grayscale  (grayscale_reg),
        .tone       (tone_d),
        .gray       (gray),
        .pix_out    (pix_out)
    );

    assign red_out   = pix_out[0];
    assign green_out = pix_out[1];
    assign blue_out  = pix_out[2];

    // Input backs up only when every stage holds a word and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&stage_valid) && out_stall))
        else $error("input stalled with room in the pipeline");

    // Checks that a word entering an empty pipeline raises out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (stage_valid == '0)) |=> ##5 out_valid)
        else $error("word did not reach the output on time");

    // With no word in or out, the number of words in flight is unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && !in_stall) && !(out_valid && !out_stall))
        |=> ($countones(stage_valid) == $past($countones(stage_valid))))
        else $error("word lost or duplicated inside the pipeline");

endmodule

// File: hw/rtl/pta_ctrl.sv
`timescale 1ns / 1ps

module pta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output logic [pta_pkg::NUM_STAGES-1:0] stage_valid,
    output pta_pkg::pipe_ctl_t ctl
);
    import pta_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // A stage loads when it is empty or its word moves on this cycle
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load    = load;
    assign in_stall    = !load[0];
    assign out_valid   = valid_reg[NUM_STAGES-1];
    assign stage_valid = valid_reg;

endmodule

// File: hw/rtl/pta_tone.sv
`timescale 1ns / 1ps

module pta_tone (
    input  logic                clk,
    input  logic                load_num,
    input  logic                load_tone,
    input  logic signed [7:0]   brightness,
    input  logic signed [7:0]   contrast,
    input  pta_pkg::pixel_t     pix,
    output pta_pkg::pixel_t     tone
);
    import pta_pkg::*;

    logic signed [8:0]       gain;
    logic signed [NUM_W-1:0] bright_term;
    logic signed [8:0]       diff      [NUM_CH];
    logic signed [NUM_W-1:0] num_next  [NUM_CH];
    logic signed [NUM_W-1:0] num_reg   [NUM_CH];
    pixel_t                  tone_next;
    pixel_t                  tone_reg;

    // Stage one: contrast about mid-gray plus brightness, scaled by 100
    always_comb
    begin
        gain        = 9'sd100 + 9'(contrast);
        bright_term = 18'(brightness) * 18'sd255;
        for (int c = 0; c < NUM_CH; c++)
        begin
            diff[c]     = $signed({1'b0, pix[c]}) - 9'sd128;
            num_next[c] = 18'(diff[c]) * 18'(gain) + bright_term + 18'sd12800;
        end
    end

    // Stage two: floor divide by 100 and clamp
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            tone_next[c] = div100_clamp(num_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_num)
        begin
            num_reg <= num_next;
        end
        if (load_tone)
        begin
            tone_reg <= tone_next;
        end
    end

    assign tone = tone_reg;

endmodule

// File: hw/rtl/pta_luma.sv
`timescale 1ns / 1ps

module pta_luma (
    input  logic               clk,
    input  logic               load_sum,
    input  logic               load_gray,
    input  pta_pkg::pixel_t    tone,
    output pta_pkg::pixel_t    tone_d,
    output logic [7:0]         gray
);
    import pta_pkg::*;

    localparam int SUM_W = 18;
    // floor(s / 1000) as (s * 268436) >> 28, exact for s < 493447
    localparam logic [18:0] RECIP1000 = 19'd268436;
    localparam int          SHIFT1000 = 28;

    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic [36:0]      gray_prod;
    pixel_t           tone_s3_reg;
    pixel_t           tone_s4_reg;
    logic [7:0]       gray_reg;

    always_comb
    begin
        sum_next = 18'(tone[0]) * 18'd299
                 + 18'(tone[1]) * 18'd587
                 + 18'(tone[2]) * 18'd114;
        gray_prod = 37'(sum_reg) * 37'(RECIP1000);
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            sum_reg     <= sum_next;
            tone_s3_reg <= tone;
        end
        if (load_gray)
        begin
            gray_reg    <= gray_prod[SHIFT1000+7:SHIFT1000];
            tone_s4_reg <= tone_s3_reg;
        end
    end

    assign tone_d = tone_s4_reg;
    assign gray   = gray_reg;

endmodule

// File: hw/rtl/pta_mix.sv
`timescale 1ns / 1ps

module pta_mix (
    input  logic               clk,
    input  logic               load_num,
    input  logic               load_out,
    input  logic signed [7:0]  saturation,
    input  logic               grayscale,
    input  pta_pkg::pixel_t    tone,
    input  logic [7:0]         gray,
    output pta_pkg::pixel_t    pix_out
);
    import pta_pkg::*;

    logic signed [8:0]       k;
    logic signed [NUM_W-1:0] gray_term;
    logic signed [8:0]       diff     [NUM_CH];
    logic signed [NUM_W-1:0] num_next [NUM_CH];
    logic signed [NUM_W-1:0] num_reg  [NUM_CH];
    pixel_t                  out_next;
    pixel_t                  out_reg;

    // Stage five: pull each channel toward or away from luma, scaled by 100
    always_comb
    begin
        k         = grayscale ? 9'sd0 : 9'sd100 + 9'(saturation);
        gray_term = $signed({10'd0, gray}) * 18'sd100;
        for (int c = 0; c < NUM_CH; c++)
        begin
            diff[c]     = $signed({1'b0, tone[c]}) - $signed({1'b0, gray});
            num_next[c] = gray_term + 18'(diff[c]) * 18'(k);
        end
    end

    // Stage six: divide by 100 and clamp into the output register
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_next[c] = div100_clamp(num_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_num)
        begin
            num_reg <= num_next;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign pix_out = out_reg;

endmodule
